// File: design/dgsp_pkg.sv
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared constants for the distance gain stereo panner: coordinate width,
// defaults, register map and the arctangent table of the rotation pipeline.
// ----------------------------------------------------------------------------
package dgsp_pkg;

   localparam int COORD_BITS             = 24;
   localparam int GAIN_FRAC_BITS_DEFAULT = 15;

   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 31;

   localparam int          CSR_ADDR_W         = 3;
   localparam logic [23:0] MAX_DISTANCE_RESET = 24'd1024;
   localparam logic        REG_MAX_DISTANCE   = 1'b0;

   localparam logic [31:0] ATAN_STEPS [0:CORDIC_STEPS-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
      32'd1
   };

endpackage

// File: design/distance_gain_stereo_panner_core.sv
// ----------------------------------------------------------------------------
// distance_gain_stereo_panner_core
// Distance volume and sine-law stereo pan from source and listener positions.
// Throughput: one beat per cycle; the whole pipeline holds while rsp stalls.
// Depth is set by two 32-step square root chains (the 31-step rotation shares
// the first) and the restoring divisions, one step per register stage.
// Reset clears the valid bits and sets max_distance to 1024.
// ----------------------------------------------------------------------------
module distance_gain_stereo_panner_core #(
   parameter int GAIN_FRAC_BITS = dgsp_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // source_x, source_y, source_z, ear_x, ear_y, ear_z, heading
   input  logic [((6*dgsp_pkg::COORD_BITS+16+7)/8)*8-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // volume, pan_left, pan_right
   output logic [47:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [dgsp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   localparam int CB  = dgsp_pkg::COORD_BITS;
   localparam int G   = GAIN_FRAC_BITS;
   localparam int SQ  = dgsp_pkg::SQRT_STEPS;
   localparam int NST = 3 + (SQ + 1) + 1 + (SQ + 1) + (G + 2);
   localparam logic [G:0] UNITY = {1'b1, {G{1'b0}}};
   localparam logic signed [33:0] Z_HALF_NEG = -34'sd2147483648;
   localparam logic signed [33:0] Z_FULL     = 34'sd4294967296;
   localparam logic signed [33:0] Z_HALF     = 34'sd2147483648;
   localparam logic signed [33:0] Z_QTR      = 34'sd1073741824;

   typedef struct packed {
      logic signed [CB:0] dx;
      logic signed [CB:0] dy;
      logic signed [CB:0] dz;
      logic [15:0]        hd;
   } s0_type;

   typedef struct packed {
      logic                oor;
      logic [23:0]         ax;
      logic [23:0]         ay;
      logic [23:0]         az;
      logic signed [24:0]  sx;
      logic signed [24:0]  sz;
      logic [15:0]         hd;
   } s1_type;

   typedef struct packed {
      logic                oor;
      logic [47:0]         qx;
      logic [47:0]         qy;
      logic [47:0]         qz;
      logic signed [24:0]  x;
      logic signed [24:0]  y;
      logic [4:0]          sh;
      logic signed [33:0]  z;
   } s2_type;

   typedef struct packed {
      logic                oor;
      logic [63:0]         vn;
      logic [63:0]         vr;
      logic signed [33:0]  cx;
      logic signed [33:0]  cy;
      logic signed [33:0]  cz;
   } a_type;

   typedef struct packed {
      logic        oor;
      logic [31:0] d7;
      logic [63:0] px;
      logic [63:0] py;
      logic [31:0] my;
      logic        ysg;
   } m_type;

   typedef struct packed {
      logic        oor;
      logic [31:0] d7;
      logic [63:0] n;
      logic [63:0] r;
      logic [31:0] my;
      logic        ysg;
   } b_type;

   typedef struct packed {
      logic        oor;
      logic        ysg;
      logic        rz;
      logic [33:0] vrem;
      logic [33:0] prem;
      logic [33:0] pd;
      logic [G:0]  vq;
      logic [G:0]  pq;
   } c_type;

   typedef struct packed {
      logic [63:0] n;
      logic [63:0] r;
   } sq_type;

   function automatic sq_type sqrt_step(input logic [63:0] n, input logic [63:0] r,
                                        input int unsigned k);
      logic [63:0] bt;
      logic [64:0] tr;
      sq_type      o;
      bt = 64'd1 << (62 - 2 * k);
      tr = {1'b0, r} + {1'b0, bt};
      if ({1'b0, n} >= tr) begin
         o.n = n - tr[63:0];
         o.r = (r >> 1) + bt;
      end else begin
         o.n = n;
         o.r = r >> 1;
      end
      return o;
   endfunction

   logic        adv;
   logic        write_hit;
   logic [23:0] max_ff, max_in;
   logic [47:0] mm_ff, mm_in;
   logic [30:0] m7;

   logic [NST-1:0] v_ff, v_in;
   s0_type s0_ff, s0_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   a_type  a_ff [0:SQ];
   a_type  a_in [0:SQ];
   m_type  m_ff, m_in;
   b_type  b_ff [0:SQ];
   b_type  b_in [0:SQ];
   c_type  c_ff [0:G+1];
   c_type  c_in [0:G+1];

   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic [G:0]  vol_w, left_w, right_w;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign max_in     = (write_hit && csr_paddr[dgsp_pkg::CSR_ADDR_W-1] ==
                        dgsp_pkg::REG_MAX_DISTANCE) ? csr_pwdata[23:0] : max_ff;
   assign mm_in      = 48'(max_ff) * 48'(max_ff);
   assign m7         = {max_ff, 7'b0};
   assign csr_prdata = (csr_paddr[dgsp_pkg::CSR_ADDR_W-1] == dgsp_pkg::REG_MAX_DISTANCE)
                       ? {8'b0, max_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= dgsp_pkg::MAX_DISTANCE_RESET;
      end else begin
         max_ff <= max_in;
      end
      mm_ff <= mm_in;
   end

   // ---------------------------------------------------------------- control
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign v_in       = {v_ff[NST-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= v_in;
         rsp_valid_ff <= v_ff[NST-1];
      end
   end

   // ---------------------------------------------------------------- offsets
   always_comb begin
      s0_in.dx = (CB+1)'($signed(req_tdata[CB-1:0])) -
                 (CB+1)'($signed(req_tdata[4*CB-1:3*CB]));
      s0_in.dy = (CB+1)'($signed(req_tdata[2*CB-1:CB])) -
                 (CB+1)'($signed(req_tdata[5*CB-1:4*CB]));
      s0_in.dz = (CB+1)'($signed(req_tdata[3*CB-1:2*CB])) -
                 (CB+1)'($signed(req_tdata[6*CB-1:5*CB]));
      s0_in.hd = req_tdata[6*CB+15:6*CB];
   end

   // ---------------------------------------------------------------- range
   always_comb begin
      logic [CB:0] mx, my, mz;
      mx = s0_ff.dx[CB] ? (~s0_ff.dx + 1'b1) : s0_ff.dx;
      my = s0_ff.dy[CB] ? (~s0_ff.dy + 1'b1) : s0_ff.dy;
      mz = s0_ff.dz[CB] ? (~s0_ff.dz + 1'b1) : s0_ff.dz;
      s1_in.oor = (33'(mx) > 33'(max_ff)) || (33'(my) > 33'(max_ff)) ||
                  (33'(mz) > 33'(max_ff));
      s1_in.ax  = 24'(mx);
      s1_in.ay  = 24'(my);
      s1_in.az  = 24'(mz);
      s1_in.sx  = 25'(s0_ff.dx);
      s1_in.sz  = 25'(s0_ff.dz);
      s1_in.hd  = s0_ff.hd;
   end

   // ---------------------------------------------------------------- squares, angle
   always_comb begin
      logic signed [24:0] xz;
      logic [24:0]        bx, by, big;
      logic [4:0]         msb;
      logic signed [33:0] z;
      logic               neg;
      s2_in.oor = s1_ff.oor;
      s2_in.qx  = s1_ff.ax * s1_ff.ax;
      s2_in.qy  = s1_ff.ay * s1_ff.ay;
      s2_in.qz  = s1_ff.az * s1_ff.az;
      xz = (s1_ff.sx == '0 && s1_ff.sz == '0) ? 25'sd1 : s1_ff.sz;
      bx = xz[24] ? 25'(-xz) : 25'(xz);
      by = s1_ff.sx[24] ? 25'(-s1_ff.sx) : 25'(s1_ff.sx);
      big = (bx > by) ? bx : by;
      msb = '0;
      for (int i = 0; i < 25; i++) begin
         if (big[i]) msb = 5'(i);
      end
      s2_in.sh = 5'd29 - msb;
      z = -$signed({2'b00, s1_ff.hd, 16'b0});
      if (z < Z_HALF_NEG) z = z + Z_FULL;
      neg = 1'b0;
      if (z > Z_QTR) begin
         neg = 1'b1;
         z   = z - Z_HALF;
      end else if (z < -Z_QTR) begin
         neg = 1'b1;
         z   = z + Z_HALF;
      end
      s2_in.z = z;
      s2_in.x = neg ? -xz : xz;
      s2_in.y = neg ? -s1_ff.sx : s1_ff.sx;
   end

   // ---------------------------------------------------------------- sum, normalise
   always_comb begin
      logic [49:0] sum;
      sum = 50'(s2_ff.qx) + 50'(s2_ff.qy) + 50'(s2_ff.qz);
      a_in[0].oor = s2_ff.oor || (sum > 50'(mm_ff));
      a_in[0].vn  = {sum, 14'b0};
      a_in[0].vr  = '0;
      a_in[0].cx  = 34'(s2_ff.x) <<< s2_ff.sh;
      a_in[0].cy  = 34'(s2_ff.y) <<< s2_ff.sh;
      a_in[0].cz  = s2_ff.z;
   end

   // ---------------------------------------------------------------- distance root, rotation
   for (genvar k = 1; k <= SQ; k++) begin : g_rot
      always_comb begin
         sq_type sv;
         a_type  p;
         p  = a_ff[k-1];
         sv = sqrt_step(p.vn, p.vr, k - 1);
         a_in[k]     = p;
         a_in[k].vn  = sv.n;
         a_in[k].vr  = sv.r;
         if (k - 1 < dgsp_pkg::CORDIC_STEPS) begin
            if (p.cz >= 0) begin
               a_in[k].cx = p.cx - (p.cy >>> (k - 1));
               a_in[k].cy = p.cy + (p.cx >>> (k - 1));
               a_in[k].cz = p.cz - $signed({2'b00, dgsp_pkg::ATAN_STEPS[k-1]});
            end else begin
               a_in[k].cx = p.cx + (p.cy >>> (k - 1));
               a_in[k].cy = p.cy - (p.cx >>> (k - 1));
               a_in[k].cz = p.cz + $signed({2'b00, dgsp_pkg::ATAN_STEPS[k-1]});
            end
         end
      end
   end

   // ---------------------------------------------------------------- magnitude squares
   always_comb begin
      logic [33:0] ax, ay;
      ax = a_ff[SQ].cx[33] ? 34'(-a_ff[SQ].cx) : 34'(a_ff[SQ].cx);
      ay = a_ff[SQ].cy[33] ? 34'(-a_ff[SQ].cy) : 34'(a_ff[SQ].cy);
      m_in.oor = a_ff[SQ].oor;
      m_in.d7  = a_ff[SQ].vr[31:0];
      m_in.px  = ax[31:0] * ax[31:0];
      m_in.py  = ay[31:0] * ay[31:0];
      m_in.my  = ay[31:0];
      m_in.ysg = a_ff[SQ].cy[33];
   end

   always_comb begin
      b_in[0].oor = m_ff.oor;
      b_in[0].d7  = m_ff.d7;
      b_in[0].n   = m_ff.px + m_ff.py;
      b_in[0].r   = '0;
      b_in[0].my  = m_ff.my;
      b_in[0].ysg = m_ff.ysg;
   end

   // ---------------------------------------------------------------- radius root
   for (genvar k = 1; k <= SQ; k++) begin : g_rad
      always_comb begin
         sq_type sv;
         sv        = sqrt_step(b_ff[k-1].n, b_ff[k-1].r, k - 1);
         b_in[k]   = b_ff[k-1];
         b_in[k].n = sv.n;
         b_in[k].r = sv.r;
      end
   end

   // ---------------------------------------------------------------- divisions
   always_comb begin
      c_in[0].oor  = b_ff[SQ].oor;
      c_in[0].ysg  = b_ff[SQ].ysg;
      c_in[0].rz   = (b_ff[SQ].r == '0);
      c_in[0].vrem = 34'(m7) - 34'(b_ff[SQ].d7);
      c_in[0].prem = 34'(b_ff[SQ].my);
      c_in[0].pd   = b_ff[SQ].r[33:0];
      c_in[0].vq   = '0;
      c_in[0].pq   = '0;
   end

   for (genvar j = 0; j <= G; j++) begin : g_div
      always_comb begin
         logic [33:0] vt, pt;
         c_in[j+1] = c_ff[j];
         vt = (j == 0) ? c_ff[j].vrem : (c_ff[j].vrem << 1);
         pt = (j == 0) ? c_ff[j].prem : (c_ff[j].prem << 1);
         if (vt >= 34'(m7)) begin
            c_in[j+1].vrem = vt - 34'(m7);
            c_in[j+1].vq   = {c_ff[j].vq[G-1:0], 1'b1};
         end else begin
            c_in[j+1].vrem = vt;
            c_in[j+1].vq   = {c_ff[j].vq[G-1:0], 1'b0};
         end
         if (pt >= c_ff[j].pd) begin
            c_in[j+1].prem = pt - c_ff[j].pd;
            c_in[j+1].pq   = {c_ff[j].pq[G-1:0], 1'b1};
         end else begin
            c_in[j+1].prem = pt;
            c_in[j+1].pq   = {c_ff[j].pq[G-1:0], 1'b0};
         end
      end
   end

   // ---------------------------------------------------------------- gains
   always_comb begin
      logic [G:0] q;
      c_type      c;
      c = c_ff[G+1];
      q = c.rz ? '0 : ((c.pq > UNITY) ? UNITY : c.pq);
      if (c.oor) begin
         vol_w   = '0;
         left_w  = '0;
         right_w = '0;
      end else begin
         vol_w   = (max_ff == '0) ? UNITY : c.vq;
         left_w  = c.ysg ? UNITY : (UNITY - q);
         right_w = c.ysg ? (UNITY - q) : UNITY;
      end
      rsp_data_in = {16'(right_w), 16'(left_w), 16'(vol_w)};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff       <= s0_in;
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         a_ff        <= a_in;
         m_ff        <= m_in;
         b_ff        <= b_in;
         c_ff        <= c_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------------------------------------------------------- checks
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff) && rsp_valid_ff)
      else $error("pipeline moved while rsp stalled");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      v_ff[NST-1] && adv |=> rsp_valid_ff)
      else $error("beat lost at output stage");

   a_pan: assert property (@(posedge clock) disable iff (reset)
      v_ff[NST-1] && !c_ff[G+1].oor |-> (left_w == UNITY || right_w == UNITY))
      else $error("neither pan gain at unity");

   a_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[NST-1] |-> vol_w <= UNITY && left_w <= UNITY && right_w <= UNITY)
      else $error("gain above unity");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && v_ff == '0)
      else $error("valid bits survive reset");

endmodule

// File: tb/distance_gain_stereo_panner_core_tb.sv
// ----------------------------------------------------------------------------
// distance_gain_stereo_panner_core_tb
// Self-checking bench for the distance gain stereo panner. Position updates
// are streamed in, each one is scored against a bit-exact gain predictor
// (linear distance volume, CORDIC sine pan) and checked in order, field by
// field. Covers several max_distance settings, random gaps on both sides
// and a long result stall that backs the pipeline up.
// ----------------------------------------------------------------------------
module distance_gain_stereo_panner_core_tb;

   localparam int UNITY_SH = dgsp_pkg::GAIN_FRAC_BITS_DEFAULT;
   localparam logic [dgsp_pkg::CSR_ADDR_W-1:0] ADDR_MAX_DISTANCE =
      dgsp_pkg::CSR_ADDR_W'(4 * dgsp_pkg::REG_MAX_DISTANCE);
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [159:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [dgsp_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   logic [47:0] gains_due [$];
   logic [23:0] cur_max_dist = dgsp_pkg::MAX_DISTANCE_RESET;
   int err_count = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int settings_used = 0;
   bit tx_gaps = 1'b0;
   bit rx_gaps = 1'b0;
   int rx_holdoff = 0;
   int quiet_cycles = 0;

   distance_gain_stereo_panner_core DUT (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned magn(longint signed v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   // result beat: volume, pan_left, pan_right from the low bits up
   function automatic logic [47:0] predict_gains(logic [159:0] d);
      longint signed dx, dy, dz, x, y, z, t;
      longint unsigned ax, ay, az, s2, vol, lft, rgt, big, r, q, m, d7, m7, unity;
      int sh;
      unity = 64'd1 << UNITY_SH;
      dx = longint'(signed'(d[23:0])) - longint'(signed'(d[95:72]));
      dy = longint'(signed'(d[47:24])) - longint'(signed'(d[119:96]));
      dz = longint'(signed'(d[71:48])) - longint'(signed'(d[143:120]));
      m = cur_max_dist;
      ax = magn(dx);
      ay = magn(dy);
      az = magn(dz);
      if (ax > m || ay > m || az > m) return '0;
      s2 = ax * ax + ay * ay + az * az;
      if (s2 > m * m) return '0;
      if (m == 0) begin
         vol = unity;
      end else begin
         d7 = int_sqrt(s2 << 14);
         m7 = m << 7;
         vol = ((m7 - d7) << UNITY_SH) / m7;
      end
      if (dx == 0 && dz == 0) dz = 1;
      big = magn(dx) > magn(dz) ? magn(dx) : magn(dz);
      sh = 0;
      while (big < (64'd1 << 29)) begin
         big = big << 1;
         sh++;
      end
      x = dz <<< sh;
      y = dx <<< sh;
      z = -(longint'(d[159:144]) << 16);
      if (z < -64'sd2147483648) z = z + 64'sd4294967296;
      if (z > 64'sd1073741824) begin
         x = -x; y = -y; z = z - 64'sd2147483648;
      end else if (z < -64'sd1073741824) begin
         x = -x; y = -y; z = z + 64'sd2147483648;
      end
      for (int i = 0; i < dgsp_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(dgsp_pkg::ATAN_STEPS[i]);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(dgsp_pkg::ATAN_STEPS[i]);
         end
         x = t;
      end
      r = int_sqrt(magn(x) * magn(x) + magn(y) * magn(y));
      q = r != 0 ? (magn(y) << UNITY_SH) / r : 0;
      if (q > unity) q = unity;
      if (y < 0) begin
         lft = unity;
         rgt = unity - q;
      end else begin
         lft = unity - q;
         rgt = unity;
      end
      return {rgt[15:0], lft[15:0], vol[15:0]};
   endfunction

   task automatic report_err(input string msg);
      err_count++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (gains_due.size() == 0) begin
            report_err($sformatf("unexpected beat %h", rsp_tdata));
         end else begin
            logic [47:0] exp_g;
            exp_g = gains_due.pop_front();
            beats_checked++;
            if (rsp_tdata[15:0] !== exp_g[15:0])
               report_err($sformatf("volume %0d, want %0d", rsp_tdata[15:0], exp_g[15:0]));
            if (rsp_tdata[31:16] !== exp_g[31:16])
               report_err($sformatf("pan_left %0d, want %0d",
                  rsp_tdata[31:16], exp_g[31:16]));
            if (rsp_tdata[47:32] !== exp_g[47:32])
               report_err($sformatf("pan_right %0d, want %0d",
                  rsp_tdata[47:32], exp_g[47:32]));
         end
      end
   end

   // result side readiness: random stall bursts plus a counted hold-off
   always @(posedge clock) begin
      static int stall_left = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_holdoff > 0) begin
         rx_holdoff <= rx_holdoff - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (!req_tvalid && gains_due.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results pending", gains_due.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pos(input logic [159:0] d);
      if (tx_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tdata <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gains_due.push_back(predict_gains(d));
      beats_sent++;
   endtask

   function automatic logic [159:0] pack_pos(int sx, int sy, int sz,
                                             int ex, int ey, int ez, int hd);
      return {hd[15:0], ez[23:0], ey[23:0], ex[23:0], sz[23:0], sy[23:0], sx[23:0]};
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (gains_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(input logic [23:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_MAX_DISTANCE;
      csr_pwdata <= {8'h00, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_max_dist = val;
      settings_used++;
   endtask

   task automatic csr_check();
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_MAX_DISTANCE;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[23:0] !== cur_max_dist)
         report_err($sformatf("max_distance reads %0d, want %0d",
            csr_prdata[23:0], cur_max_dist));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [159:0] rand_pos(logic [23:0] m);
      int ex, ey, ez, rng;
      ex = $urandom;
      ey = $urandom;
      ez = $urandom;
      if ($urandom_range(0, 4) == 0)
         return {$urandom, $urandom, $urandom, $urandom, $urandom};
      rng = $urandom_range(0, 2) == 0 ? int'(m) : int'(m) / 2;
      return pack_pos(ex + int'($urandom_range(0, 2 * rng)) - rng,
                      ey + int'($urandom_range(0, 2 * rng)) - rng,
                      ez + int'($urandom_range(0, 2 * rng)) - rng,
                      ex, ey, ez, $urandom);
   endfunction

   task automatic test_reset_value();
      csr_check();
   endtask

   task automatic test_directed();
      int m;
      m = cur_max_dist;
      send_pos(pack_pos(0, 0, 0, 0, 0, 0, 0));
      send_pos(pack_pos(5, 7, 5, 5, 0, 5, 16384));
      send_pos(pack_pos(0, 0, 0, 0, 0, 0, 32768));
      send_pos(pack_pos(0, 0, 0, 0, 0, 0, 49152));
      send_pos(pack_pos(0, 0, 0, 0, 0, 0, 65535));
      send_pos(pack_pos(m, 0, 0, 0, 0, 0, 0));
      send_pos(pack_pos(-m, 0, 0, 0, 0, 0, 16384));
      send_pos(pack_pos(0, m, 0, 0, 0, 0, 0));
      send_pos(pack_pos(0, 0, -m, 0, 0, 0, 32768));
      send_pos(pack_pos(m + 1, 0, 0, 0, 0, 0, 0));
      send_pos(pack_pos(m / 2 + 300, m / 2 + 300, m / 2 + 300, 0, 0, 0, 0));
      send_pos(pack_pos(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 0));
      send_pos(pack_pos(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                        65535));
      send_pos(pack_pos(8388607, 0, 8388607, 8388607, 0, 8388607, 12345));
      send_pos(pack_pos(100, 3, -100, 0, 0, 0, 8192));
      send_pos(pack_pos(-37, 0, 1, 0, 0, 0, 40000));
      drain();
      csr_write(24'd1);
      send_pos(pack_pos(1, 0, 0, 0, 0, 0, 0));
      send_pos(pack_pos(0, 0, -1, 0, 0, 0, 100));
      send_pos(pack_pos(1, 1, 0, 0, 0, 0, 0));
      drain();
      csr_write(24'hFFFFFF);
      csr_check();
      send_pos(pack_pos(8388607, 0, 0, -8388608, 0, 0, 0));
      send_pos(pack_pos(0, 0, -8388608, 0, 0, 8388607, 30000));
      send_pos(pack_pos(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 7));
      drain();
   endtask

   task automatic test_random_settings();
      logic [23:0] sets [5];
      sets = '{24'd1024, 24'd3, 24'hFFFFFF, 24'd0, 24'd70000};
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      foreach (sets[k]) begin
         csr_write(k == 3 ? 24'($urandom_range(1, 24'hFFFFFF)) : sets[k]);
         csr_check();
         repeat (120) send_pos(rand_pos(cur_max_dist));
         drain();
      end
   endtask

   task automatic test_backpressure();
      csr_write(24'd5000);
      rx_holdoff = 400;
      repeat (150) send_pos(rand_pos(cur_max_dist));
      drain();
   endtask

   task automatic test_steady_stream();
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      csr_write(24'd2000);
      repeat (130) send_pos(rand_pos(cur_max_dist));
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_value();
      test_directed();
      test_random_settings();
      test_backpressure();
      test_steady_stream();
      $display("Sent %0d position beats, checked %0d gain beats", beats_sent, beats_checked);
      $display("across %0d max_distance settings, with gaps and a long stall",
         settings_used);
      if (err_count == 0 && gains_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
